/* rtl/prc_pkg.sv */
package prc_pkg;

    // FNV-1a constants (32-bit variant).
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;

    // Bytes fed into the hash per record, one per cell.
    localparam int NUM_CELLS = 16;
    localparam int REC_BITS  = 8 * NUM_CELLS;

    // Enum limits of the record fields.
    localparam logic [7:0] MODE_MAX    = 8'd2;
    localparam logic [7:0] PRIVACY_MAX = 8'd2;
    localparam logic [7:0] TUNNEL_MAX  = 8'd2;

    // Connection mode codes.
    localparam logic [7:0] MODE_OFFGRID  = 8'd0;
    localparam logic [7:0] MODE_INTERNET = 8'd1;
    localparam logic [7:0] MODE_SMART    = 8'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAGIC   = 2'd0;
    localparam logic [1:0] REG_VERSION = 2'd1;

    // Reject reason codes.
    localparam logic [1:0] REJ_NONE       = 2'd0;
    localparam logic [1:0] REJ_INVALID    = 2'd1;
    localparam logic [1:0] REJ_NO_WIFI    = 2'd2;
    localparam logic [1:0] REJ_TUNNEL_OFF = 2'd3;

    // Per-record side information that rides along the hash chain.
    typedef struct packed {
        logic [31:0] stored_sum;
        logic        pre_ok;
        logic        offgrid_perm;
        logic        inet_perm;
        logic        inet_excl;
        logic        smart_sel;
        logic        priv_max;
        logic        tunnel_req;
        logic        wifi;
        logic        tun_up;
    } side_t;

endpackage

/* rtl/prc_cell.sv */
module prc_cell
    import prc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         in_hash,
    input  logic [REC_BITS-1:0] in_bytes,
    input  side_t               in_side,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_hash,
    output logic [REC_BITS-1:0] out_bytes,
    output side_t               out_side
);

    logic                valid_reg;
    logic [31:0]         hash_reg;
    logic [31:0]         hash_next;
    logic [REC_BITS-1:0] bytes_reg;
    side_t               side_reg;

    // The cell takes a new item when it is empty or its item moves on.
    assign in_ready = !valid_reg || out_ready;

    // One FNV-1a round on the lowest pending byte: xor, then multiply mod 2^32.
    assign hash_next = (in_hash ^ {24'd0, in_bytes[7:0]}) * FNV_PRIME;

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload: the consumed byte is dropped and the remaining bytes shift down toward the next cell.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hash_reg  <= hash_next;
            bytes_reg <= {8'd0, in_bytes[REC_BITS-1:8]};
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_hash  = hash_reg;
    assign out_bytes = bytes_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/policy_record_check_fnv1a.sv */
// Policy record checker. Each transfer carries one stored policy record and two
// capability flags; the block hashes the record's 16 bytes with 32-bit FNV-1a,
// checks magic, version, enum ranges and the stored checksum, and reports
// whether internet use is allowed together with a reject reason and mode flags.
// The hash runs through a chain of 16 byte cells, one multiplier per cell; each
// cell registers its hash, and the last cell's register drives the result. A new
// record is accepted every cycle while the output is not stalled. When the output
// stalls the chain fills and then holds; in_stall rises only once all 16 cells are
// occupied. Configuration writes (index 0 magic, index 1 version) are always
// ready and are registered; other indexes are ignored.
module policy_record_check_fnv1a
    import prc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Record input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] rec_magic,
    input  logic [15:0] rec_version,
    input  logic [7:0]  conn_mode,
    input  logic [7:0]  privacy_level,
    input  logic [7:0]  tunnel_rule,
    input  logic [7:0]  spare_byte,
    input  logic [15:0] spare_half,
    input  logic [31:0] generation_count,
    input  logic [31:0] stored_sum,
    input  logic        wifi_ready,
    input  logic        tunnel_up,
    // Result output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] computed_sum,
    output logic        record_ok,
    output logic        internet_allowed,
    output logic [1:0]  reject_code,
    output logic        offgrid_permitted,
    output logic        internet_permitted,
    output logic        internet_exclusive,
    output logic        smart_selected,
    output logic        privacy_maximal
);

    logic [31:0] exp_magic_reg;
    logic [15:0] exp_version_reg;

    logic                chain_valid [0:NUM_CELLS];
    logic                chain_ready [0:NUM_CELLS];
    logic [31:0]         chain_hash  [0:NUM_CELLS];
    logic [REC_BITS-1:0] chain_bytes [0:NUM_CELLS];
    side_t               chain_side  [0:NUM_CELLS];

    side_t entry_side;
    side_t tail_side;
    logic  ok;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_magic_reg   <= '0;
            exp_version_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAGIC:   exp_magic_reg   <= cfg_data;
                REG_VERSION: exp_version_reg <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // Entry checks that do not depend on the hash are resolved up front.
    always_comb
    begin
        entry_side.stored_sum   = stored_sum;
        entry_side.pre_ok       = (rec_magic == exp_magic_reg)
                                  && (rec_version == exp_version_reg)
                                  && (conn_mode <= MODE_MAX)
                                  && (privacy_level <= PRIVACY_MAX)
                                  && (tunnel_rule <= TUNNEL_MAX);
        entry_side.offgrid_perm = (conn_mode == MODE_OFFGRID) || (conn_mode == MODE_SMART);
        entry_side.inet_perm    = (conn_mode == MODE_INTERNET) || (conn_mode == MODE_SMART);
        entry_side.inet_excl    = (conn_mode == MODE_INTERNET);
        entry_side.smart_sel    = (conn_mode == MODE_SMART);
        entry_side.priv_max     = (privacy_level == PRIVACY_MAX);
        entry_side.tunnel_req   = (tunnel_rule == TUNNEL_MAX);
        entry_side.wifi         = wifi_ready;
        entry_side.tun_up       = tunnel_up;
    end

    // Head of the chain: record bytes in hash order, least significant first.
    assign chain_valid[0] = in_valid;
    assign chain_hash[0]  = FNV_BASIS;
    assign chain_bytes[0] = {generation_count, spare_half, spare_byte, tunnel_rule,
                             privacy_level, conn_mode, rec_version, rec_magic};
    assign chain_side[0]  = entry_side;
    assign in_stall       = !chain_ready[0];

    // Chain of byte cells.
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        prc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_hash   (chain_hash[i]),
            .in_bytes  (chain_bytes[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_hash  (chain_hash[i+1]),
            .out_bytes (chain_bytes[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // The last cell's register is the output register.
    assign chain_ready[NUM_CELLS] = !out_stall;
    assign out_valid              = chain_valid[NUM_CELLS];
    assign tail_side              = chain_side[NUM_CELLS];

    // Final verdict from the finished hash.
    assign ok = tail_side.pre_ok && (tail_side.stored_sum == chain_hash[NUM_CELLS]);

    always_comb
    begin
        internet_allowed = 1'b0;
        if (!ok)
        begin
            reject_code = REJ_INVALID;
        end
        else if (!tail_side.inet_perm)
        begin
            reject_code = REJ_NONE;
        end
        else if (!tail_side.wifi)
        begin
            reject_code = REJ_NO_WIFI;
        end
        else if (tail_side.tunnel_req && !tail_side.tun_up)
        begin
            reject_code = REJ_TUNNEL_OFF;
        end
        else
        begin
            reject_code      = REJ_NONE;
            internet_allowed = 1'b1;
        end
    end

    assign computed_sum       = chain_hash[NUM_CELLS];
    assign record_ok          = ok;
    assign offgrid_permitted  = tail_side.offgrid_perm;
    assign internet_permitted = tail_side.inet_perm;
    assign internet_exclusive = tail_side.inet_excl;
    assign smart_selected     = tail_side.smart_sel;
    assign privacy_maximal    = tail_side.priv_max;

    // The input only stalls when the whole chain is backed up behind the output.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the chain has room");

    // An allowed result is always a valid record with no reject reason.
    a_allowed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && internet_allowed) |-> (record_ok && reject_code == REJ_NONE))
        else $error("internet allowed with a reject reason or bad record");

    // A bad record always reports the invalid reason.
    a_invalid_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !record_ok) |-> (reject_code == REJ_INVALID && !internet_allowed))
        else $error("bad record without invalid reject reason");

    // Both permissions together only happen in smart mode.
    a_mode_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && offgrid_permitted && internet_permitted) |->
            (smart_selected && !internet_exclusive))
        else $error("mode flags inconsistent");

endmodule
